// ===== sv/mzd_pkg.sv =====
// Package for the min z-score deviation block: fixed-point widths, the request
// and result structs, and the divider status struct.
// No dependencies.
package mzd_pkg;

  localparam int FRAC_BITS = 8;
  localparam int PIX_W     = 16;
  localparam int VAL_W     = 24;
  localparam int CNT_W     = 16;
  localparam int DIST_W    = (PIX_W + FRAC_BITS > VAL_W) ? PIX_W + FRAC_BITS : VAL_W;
  localparam int NUM_W     = DIST_W + FRAC_BITS;
  localparam int QCNT_W    = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] deviation;
    logic [CNT_W-1:0] model_count;
    logic             first_condition;
    logic             last_condition;
  } mzd_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_deviation;
    logic             result_valid;
  } mzd_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mzd_div_status_t;

endpackage

// ===== sv/min_zscore_deviation_top.sv =====
// Top level of the min z-score deviation block: distance front end, running
// minimum over conditions and registered result. Depends on mzd_pkg, mzd_div.
// Flow: a condition that needs division passes ST_LOAD, ST_DIV and ST_UPDATE;
// a skipped one goes straight to ST_UPDATE; a saturated one gets an early done.
// One request in flight at a time; divides use the 24-step bit-serial divider.
// Reset: synchronous; clears depth_mode, running minimum, seen flag and output.
module min_zscore_deviation_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mzd_pkg::mzd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mzd_pkg::mzd_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import mzd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_UPDATE} state_t;

  state_t            state;
  logic              depth_mode;
  logic [VAL_W-1:0]  running_minimum;
  logic              seen_valid;
  logic [NUM_W-1:0]  num;
  logic [VAL_W-1:0]  dev;
  logic              cond_ok;
  logic              first;
  logic              last;

  logic [DIST_W-1:0] pix_s;
  logic [DIST_W-1:0] mean_x;
  logic [DIST_W-1:0] distance;
  logic              mode_ok;
  logic              accept;
  logic              out_free;
  logic              emit;
  logic              base_seen;
  logic              take;
  logic [VAL_W-1:0]  min_next;
  logic              seen_next;

  mzd_div_status_t   div_status;
  logic [VAL_W-1:0]  quotient;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign emit     = (state == ST_UPDATE) && last && out_free;

  always_comb begin
    if (depth_mode) begin
      pix_s   = DIST_W'(in_data.pixel) << FRAC_BITS;
      mode_ok = (in_data.pixel != '0) && !in_data.pixel[PIX_W-1] &&
                (in_data.model_count != '0);
    end else begin
      pix_s   = DIST_W'(in_data.pixel[7:0]) << FRAC_BITS;
      mode_ok = 1'b1;
    end
    mean_x   = DIST_W'(in_data.mean);
    distance = (pix_s >= mean_x) ? pix_s - mean_x : mean_x - pix_s;
  end

  // minimum update against the base left by the first-condition mark
  always_comb begin
    base_seen = seen_valid && !first;
    take      = cond_ok && (!base_seen || quotient < running_minimum);
    min_next  = take ? quotient : (first ? '0 : running_minimum);
    seen_next = base_seen || take;
  end

  mzd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_LOAD),
    .numerator (num),
    .divisor   (dev),
    .status    (div_status),
    .quotient  (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      depth_mode      <= 1'b0;
      running_minimum <= '0;
      seen_valid      <= 1'b0;
      out_valid       <= 1'b0;
      cond_ok         <= 1'b0;
      first           <= 1'b0;
      last            <= 1'b0;
    end else begin
      if (cfg_we) begin
        depth_mode <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            num     <= NUM_W'(distance) << FRAC_BITS;
            dev     <= in_data.deviation;
            cond_ok <= mode_ok && !((distance == '0) && (in_data.deviation == '0));
            first   <= in_data.first_condition;
            last    <= in_data.last_condition;
            state   <= (mode_ok && !((distance == '0) && (in_data.deviation == '0))) ?
                       ST_LOAD : ST_UPDATE;
          end
        end
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (div_status.done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (!last) begin
            running_minimum <= min_next;
            seen_valid      <= seen_next;
            state           <= ST_IDLE;
          end else if (out_free) begin
            out_data.min_deviation <= seen_next ? min_next : '0;
            out_data.result_valid  <= seen_next;
            running_minimum        <= '0;
            seen_valid             <= 1'b0;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_status.busy)
    else $error("request taken while divider busy");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_valid |-> out_data.min_deviation == '0)
    else $error("invalid result carries nonzero value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second request taken while first in flight");

endmodule

// ===== sv/mzd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, saturating to VAL_W bits.
// Depends on mzd_pkg.
module mzd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mzd_pkg::NUM_W-1:0]  numerator,
  input  logic [mzd_pkg::VAL_W-1:0]  divisor,
  output mzd_pkg::mzd_div_status_t   status,
  output logic [mzd_pkg::VAL_W-1:0]  quotient
);
  import mzd_pkg::*;

  typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

  dv_state_t         state;
  logic              done;
  logic [QCNT_W-1:0] cnt;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  shreg;
  logic [VAL_W-1:0]  dev;

  logic [NUM_W-1:0]  num_hi;
  logic              ovf;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    trial_sub;
  logic              qbit;

  // quotient overflows VAL_W bits when the upper part alone reaches the divisor
  assign num_hi    = numerator >> VAL_W;
  assign ovf       = num_hi >= NUM_W'(divisor);
  assign trial     = {rem, shreg[VAL_W-1]};
  assign trial_sub = trial - {1'b0, dev};
  assign qbit      = trial >= {1'b0, dev};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            if (ovf) begin
              quotient <= VAL_MAX;
              done     <= 1'b1;
            end else begin
              rem   <= num_hi[VAL_W-1:0];
              shreg <= numerator[VAL_W-1:0];
              dev   <= divisor;
              cnt   <= '0;
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem      <= qbit ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
          shreg    <= {shreg[VAL_W-2:0], 1'b0};
          quotient <= {quotient[VAL_W-2:0], qbit};
          cnt      <= cnt + 1'b1;
          if (cnt == QCNT_W'(VAL_W - 1)) begin
            done  <= 1'b1;
            state <= DV_IDLE;
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  assign status.busy = (state == DV_RUN);
  assign status.done = done;

endmodule

// ===== dv/min_zscore_deviation_checker.sv =====
// Checker for min_zscore_deviation_top: watches the request, result and config
// ports, predicts each pixel's smallest z-score distance and compares results.
// Depends on mzd_pkg.
module min_zscore_deviation_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  mzd_pkg::mzd_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  mzd_pkg::mzd_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output int                mismatch_count,
  output int                results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mzd_pkg::*;

  logic             depth_on;
  logic [VAL_W-1:0] min_so_far;
  logic             any_valid;
  mzd_out_t         expected_minima[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns checker: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // |pixel*2^F - mean| * 2^F / deviation, saturated; 0 means the condition drops out
  function automatic logic zscore_distance(input logic [PIX_W-1:0] pix,
                                           input logic [VAL_W-1:0] mean,
                                           input logic [VAL_W-1:0] dev,
                                           output logic [VAL_W-1:0] q);
    logic [63:0] scaled;
    logic [63:0] diff;
    logic [63:0] quot;
    scaled = 64'(pix) << FRAC_BITS;
    diff = (scaled >= 64'(mean)) ? scaled - 64'(mean) : 64'(mean) - scaled;
    q = VAL_MAX;
    if (dev == '0) return diff != 0;
    quot = (diff << FRAC_BITS) / 64'(dev);
    q = (quot > 64'(VAL_MAX)) ? VAL_MAX : quot[VAL_W-1:0];
    return 1'b1;
  endfunction

  task automatic predict_min_deviation(input mzd_in_t req);
    logic [PIX_W-1:0] pix;
    logic [VAL_W-1:0] q;
    logic             usable;
    mzd_out_t         res;
    pix = req.pixel;
    if (req.first_condition) begin
      min_so_far = '0;
      any_valid = 1'b0;
    end
    if (depth_on) begin
      usable = !req.pixel[PIX_W-1] && req.pixel != '0 && req.model_count != '0;
    end else begin
      usable = 1'b1;
      pix = {8'h00, req.pixel[7:0]};
    end
    if (usable) usable = zscore_distance(pix, req.mean, req.deviation, q);
    if (usable && (!any_valid || q < min_so_far)) begin
      min_so_far = q;
      any_valid = 1'b1;
    end
    if (req.last_condition) begin
      res.min_deviation = any_valid ? min_so_far : '0;
      res.result_valid = any_valid;
      expected_minima.push_back(res);
      min_so_far = '0;
      any_valid = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      depth_on = 1'b0;
      min_so_far = '0;
      any_valid = 1'b0;
      expected_minima.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) depth_on = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_minima.size() == 0) begin
          report_mismatch("result with none expected", 32'(out_data), 32'h0);
        end else begin
          if (out_data.min_deviation !== expected_minima[0].min_deviation)
            report_mismatch("min_deviation", 32'(out_data.min_deviation),
                            32'(expected_minima[0].min_deviation));
          if (out_data.result_valid !== expected_minima[0].result_valid)
            report_mismatch("result_valid", 32'(out_data.result_valid),
                            32'(expected_minima[0].result_valid));
          void'(expected_minima.pop_front());
        end
      end
      if (in_valid && in_ready) predict_min_deviation(in_data);
    end
    results_outstanding = expected_minima.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the min_zscore_deviation_top testbench: clock, reset, directed and
// random condition requests, config writes and output back-pressure.
// Depends on mzd_pkg, min_zscore_deviation_top, min_zscore_deviation_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mzd_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 135;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  mzd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  mzd_out_t out_data;
  logic     cfg_we;
  logic     cfg_wdata;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int requests_sent = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_off_request = 1'b0;
  bit depth_now = 1'b0;

  min_zscore_deviation_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  min_zscore_deviation_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .mismatch_count      (mismatches),
    .results_outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic mzd_in_t make_condition(input logic [PIX_W-1:0] pix,
                                             input logic [VAL_W-1:0] mean,
                                             input logic [VAL_W-1:0] dev,
                                             input logic [CNT_W-1:0] cnt,
                                             input logic first, input logic last);
    mzd_in_t req;
    req.pixel = pix;
    req.mean = mean;
    req.deviation = dev;
    req.model_count = cnt;
    req.first_condition = first;
    req.last_condition = last;
    return req;
  endfunction

  // means often sit near the scaled pixel so that distances stay small
  function automatic mzd_in_t random_condition(input logic first, input logic last);
    logic [PIX_W-1:0] pix;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] dev;
    logic [CNT_W-1:0] cnt;
    int               centre;
    int               near;
    case ($urandom_range(0, 3))
      0: pix = PIX_W'($urandom);
      1: pix = PIX_W'($urandom_range(1, 16'h7FFF));
      2: pix = PIX_W'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 4))
          0: pix = 16'h0000;
          1: pix = 16'h0001;
          2: pix = 16'h7FFF;
          3: pix = 16'h8000;
          default: pix = 16'hFFFF;
        endcase
      end
    endcase
    centre = depth_now ? int'(pix) << FRAC_BITS : int'(pix[7:0]) << FRAC_BITS;
    case ($urandom_range(0, 3))
      0: mean = VAL_W'($urandom);
      1: begin
        near = centre + int'($urandom_range(0, 2048)) - 1024;
        if (near < 0) near = 0;
        if (near > int'(VAL_MAX)) near = int'(VAL_MAX);
        mean = VAL_W'(near);
      end
      2: mean = VAL_W'(centre);
      default: mean = $urandom_range(0, 1) ? VAL_MAX : '0;
    endcase
    case ($urandom_range(0, 5))
      0: dev = '0;
      1: dev = VAL_MAX;
      2, 3: dev = VAL_W'($urandom_range(1, 16'h0FFF));
      default: dev = VAL_W'($urandom);
    endcase
    cnt = ($urandom_range(0, 4) == 0) ? '0 : CNT_W'($urandom);
    return make_condition(pix, mean, dev, cnt, first, last);
  endfunction

  task automatic offer(input mzd_in_t req);
    int gap;
    gap = sender_idle ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic settle;
    @(negedge clk);
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_depth_mode(input logic mode);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = mode;
    depth_now = mode;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_pixel;
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) offer(random_condition(i == 0, i == n - 1));
  endtask

  task automatic run_random(input int count);
    int stop;
    stop = requests_sent + count;
    while (requests_sent < stop) begin
      if ($urandom_range(0, 15) == 0) begin
        sender_idle = $urandom_range(0, 2) != 0;
        receiver_idle = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 9) == 0)
        offer(random_condition($urandom_range(0, 1), $urandom_range(0, 1)));
      else
        send_pixel();
    end
  endtask

  // result side: random stall per result, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_request = 1'b0;
      end
      stall = receiver_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    bit phase_modes[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    write_depth_mode(1'b0);
    offer(make_condition(16'hFFFF, 24'h000000, 24'h000100, 16'h0000, 1'b1, 1'b1));
    offer(make_condition(16'h0000, VAL_MAX, 24'h000001, 16'hFFFF, 1'b1, 1'b1));
    offer(make_condition(16'h0012, 24'h001200, 24'h000000, 16'h0001, 1'b1, 1'b1));
    offer(make_condition(16'h0005, 24'h000000, 24'h000000, 16'h0001, 1'b1, 1'b1));
    offer(make_condition(16'h000A, 24'h000800, 24'h000100, 16'h0001, 1'b1, 1'b0));
    offer(make_condition(16'h0006, 24'h000800, 24'h000100, 16'h0001, 1'b0, 1'b0));
    offer(make_condition(16'h0008, 24'h000780, 24'h000100, 16'h0001, 1'b0, 1'b1));
    // no first mark: must still start fresh after the previous result
    offer(make_condition(16'h0003, 24'h000100, 24'h000200, 16'h0001, 1'b0, 1'b1));
    offer(make_condition(16'h0001, 24'h000000, 24'h000100, 16'h0001, 1'b0, 1'b0));
    offer(make_condition(16'h0002, 24'h000000, 24'h000100, 16'h0001, 1'b0, 1'b1));
    offer(make_condition(16'hAB00, 24'h000000, 24'h0000FF, 16'h0001, 1'b1, 1'b1));

    write_depth_mode(1'b1);
    offer(make_condition(16'h8000, 24'h000000, 24'h000100, 16'h0001, 1'b1, 1'b1));
    offer(make_condition(16'h0000, 24'h000000, 24'h000100, 16'h0001, 1'b1, 1'b1));
    offer(make_condition(16'h7FFF, 24'h000000, 24'h000100, 16'h0000, 1'b1, 1'b1));
    offer(make_condition(16'h7FFF, 24'h000000, VAL_MAX, 16'hFFFF, 1'b1, 1'b1));
    offer(make_condition(16'h0001, VAL_MAX, 24'h000001, 16'h8000, 1'b1, 1'b1));
    offer(make_condition(16'hFFFF, 24'h000000, 24'h000001, 16'h0001, 1'b1, 1'b1));
    offer(make_condition(16'h0100, 24'h010000, 24'h000000, 16'h0001, 1'b1, 1'b1));
    offer(make_condition(16'h0200, 24'h010000, 24'h000400, 16'h0001, 1'b1, 1'b0));
    offer(make_condition(16'h0200, 24'h000000, 24'h000100, 16'h0000, 1'b0, 1'b0));
    offer(make_condition(16'h9000, 24'h000000, 24'h000100, 16'h0001, 1'b0, 1'b1));

    for (int p = 0; p < 6; p++) begin
      write_depth_mode(phase_modes[p]);
      if (p == 2) begin
        sender_idle = 1'b0;
        hold_off_request = 1'b1;
      end
      run_random(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mzd_pkg.sv
sv/mzd_div.sv
sv/min_zscore_deviation_top.sv
dv/min_zscore_deviation_checker.sv
dv/testbench.sv
